// ===== hw/rtl/firc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// firc_pkg: shared types and constants of the circular-history FIR filter
// Item codes, fixed field widths and the control bundle to the serial MAC.
// ----------------------------------------------------------------------------
package firc_pkg;

  localparam int COEF_BITS  = 16;
  localparam int OUT_BITS   = 37;
  localparam int CFG_BITS   = 6;
  localparam int DIGIT_BITS = 8;

  localparam logic [CFG_BITS-1:0] TAPS_RESET = 6'd32;

  typedef enum logic [1:0] {
    ACT_FILTER = 2'd0,
    ACT_CLEAR  = 2'd1,
    ACT_LOAD   = 2'd2
  } action_e;

  typedef struct packed {
    logic clear;   // zero the accumulator
    logic load;    // take new operands
    logic step;    // consume one sample digit
    logic last;    // this step takes the signed top digit
    logic accum;   // add the finished product
  } mac_ctrl_t;

endpackage

// ===== hw/rtl/firc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// firc_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module firc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/firc_dsmul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// firc_dsmul: digit-serial multiply-accumulate unit
// Coefficient held in parallel, sample shifted through one digit per cycle
// with step set; low product bits refill the sample register; product summed.
// ----------------------------------------------------------------------------
module firc_dsmul #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                   clk_i,
  input  firc_pkg::mac_ctrl_t                    ctrl_i,
  input  logic signed [firc_pkg::COEF_BITS-1:0]  coef_i,
  input  logic [SAMPLE_BITS-1:0]                 sample_i,
  output logic signed [firc_pkg::OUT_BITS-1:0]   acc_o
);

  import firc_pkg::*;

  localparam int NDIG = (SAMPLE_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int SPAD = NDIG * DIGIT_BITS;
  localparam int HW   = COEF_BITS + DIGIT_BITS + 1;

  logic signed [COEF_BITS-1:0]  coef_q;
  logic [SPAD-1:0]              x_q, x_d;
  logic signed [HW-1:0]         hi_q, hi_d;
  logic signed [OUT_BITS-1:0]   acc_q;
  logic signed [DIGIT_BITS:0]   digit;
  logic signed [HW-1:0]         partial, sum;
  logic signed [HW+SPAD-1:0]    prod;

  // the top digit carries the sign of the sample
  always_comb begin
    if (ctrl_i.last) begin
      digit = {x_q[DIGIT_BITS-1], x_q[DIGIT_BITS-1:0]};
    end else begin
      digit = {1'b0, x_q[DIGIT_BITS-1:0]};
    end
    partial = coef_q * digit;
    sum     = hi_q + partial;
    hi_d    = sum >>> DIGIT_BITS;
    x_d     = (x_q >> DIGIT_BITS)
            | (SPAD'(sum[DIGIT_BITS-1:0]) << (SPAD - DIGIT_BITS));
    prod    = {hi_q, x_q};
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      coef_q <= coef_i;
      x_q    <= SPAD'($signed(sample_i));
      hi_q   <= '0;
    end else if (ctrl_i.step) begin
      x_q  <= x_d;
      hi_q <= hi_d;
    end
    if (ctrl_i.clear) begin
      acc_q <= '0;
    end else if (ctrl_i.accum) begin
      acc_q <= acc_q + OUT_BITS'(prod);
    end
  end

  assign acc_o = acc_q;

endmodule

// ===== hw/rtl/fir_filter_circular.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fir_filter_circular: direct-form FIR filter over a circular sample history
// Coefficients and samples live in two RAMs; one digit-serial MAC walks taps.
// ----------------------------------------------------------------------------
// Filter item: busy while N taps in use are swept, D = ceil(SAMPLE_BITS/8),
//   and until the result is written into the output register once free.
// Per tap: one operand load, D multiply digits, one accumulate in the MAC.
// Clear and load items are taken while idle and give no result.
// A finished result waits in the output register while new items are taken.
// Reset: both stores read as zero via per-entry valid bits, taps_in_use 32.
module fir_filter_circular #(
  parameter int TAPS        = 32,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [1:0]                            action_i,
  input  logic signed [15:0]                    sample_value_i,
  input  logic [4:0]                            tap_index_i,
  input  logic signed [15:0]                    coeff_value_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [firc_pkg::OUT_BITS-1:0]  filtered_value_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [firc_pkg::CFG_BITS-1:0]         cfg_data_i
);

  import firc_pkg::*;

  localparam int AW   = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int NW   = ($clog2(TAPS + 1) > CFG_BITS) ? $clog2(TAPS + 1) : CFG_BITS;
  localparam int NDIG = (SAMPLE_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int DCW  = (NDIG > 1) ? $clog2(NDIG) : 1;

  localparam logic [AW-1:0]  LAST_ADDR = AW'(TAPS - 1);
  localparam logic [NW-1:0]  TAPS_N    = NW'(TAPS);
  localparam logic [DCW-1:0] LAST_DIG  = DCW'(NDIG - 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_FETCH = 6'b000010,
    S_LOAD  = 6'b000100,
    S_MUL   = 6'b001000,
    S_ACC   = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  state_e                       state_q, state_d;
  logic [CFG_BITS-1:0]          taps_q;
  logic [AW-1:0]                wp_q, k_q, slot_q;
  logic [NW-1:0]                cnt_q, n_eff, taps_ext;
  logic [DCW-1:0]               dig_q;
  logic [TAPS-1:0]              coef_vld_q, hist_vld_q;
  logic                         coef_ok_q, hist_ok_q;
  logic                         out_valid_q;
  logic signed [OUT_BITS-1:0]   out_q;
  logic                         in_acc, is_filter, is_clear, is_load, out_take, out_write;
  logic                         coef_we;
  logic [AW-1:0]                coef_waddr;
  logic [COEF_BITS-1:0]         coef_rd;
  logic [SAMPLE_BITS-1:0]       hist_rd, smp_w;
  logic signed [COEF_BITS-1:0]  coef_op;
  logic [SAMPLE_BITS-1:0]       smp_op;
  logic signed [OUT_BITS-1:0]   acc;
  mac_ctrl_t                    mac_ctrl;

  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign is_filter   = in_acc && (action_i == ACT_FILTER);
  assign is_clear    = in_acc && (action_i == ACT_CLEAR);
  assign is_load     = in_acc && (action_i == ACT_LOAD);
  assign coef_we     = is_load && (32'(tap_index_i) < TAPS);
  assign coef_waddr  = AW'(tap_index_i);
  assign smp_w       = SAMPLE_BITS'($unsigned(sample_value_i));

  // clamp the tap count into one .. TAPS
  always_comb begin
    taps_ext = NW'(taps_q);
    if (taps_ext == '0) begin
      n_eff = NW'(1);
    end else if (taps_ext > TAPS_N) begin
      n_eff = TAPS_N;
    end else begin
      n_eff = taps_ext;
    end
  end

  assign out_take  = out_valid_q & ~out_stall_i;
  assign out_write = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (is_filter) begin
          state_d = S_FETCH;
        end
      end
      S_FETCH: state_d = S_LOAD;
      S_LOAD:  state_d = S_MUL;
      S_MUL: begin
        if (dig_q == LAST_DIG) begin
          state_d = S_ACC;
        end
      end
      S_ACC: begin
        if (cnt_q == n_eff) begin
          state_d = S_DONE;
        end else begin
          state_d = S_LOAD;
        end
      end
      S_DONE: begin
        if (out_write) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      taps_q      <= TAPS_RESET;
      wp_q        <= '0;
      k_q         <= '0;
      slot_q      <= '0;
      cnt_q       <= '0;
      dig_q       <= '0;
      coef_vld_q  <= '0;
      hist_vld_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        taps_q <= cfg_data_i;
      end
      if (coef_we) begin
        coef_vld_q[coef_waddr] <= 1'b1;
      end
      if (is_clear) begin
        hist_vld_q <= '0;
      end else if (is_filter) begin
        hist_vld_q[wp_q] <= 1'b1;
      end
      if (is_filter) begin
        // start the sweep at the newest sample, tap zero
        wp_q   <= (wp_q == LAST_ADDR) ? '0 : wp_q + AW'(1);
        slot_q <= wp_q;
        k_q    <= '0;
        cnt_q  <= '0;
      end else if (state_q == S_LOAD) begin
        // advance the read addresses; data settles before the next load
        k_q    <= (k_q == LAST_ADDR) ? '0 : k_q + AW'(1);
        slot_q <= (slot_q == '0) ? LAST_ADDR : slot_q - AW'(1);
        cnt_q  <= cnt_q + NW'(1);
      end
      if (state_q == S_LOAD) begin
        dig_q <= '0;
      end else if (state_q == S_MUL) begin
        dig_q <= dig_q + DCW'(1);
      end
      if (out_write) begin
        out_valid_q <= 1'b1;
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // valid flags follow the registered RAM read data
  always_ff @(posedge clk_i) begin
    coef_ok_q <= coef_vld_q[k_q];
    hist_ok_q <= hist_vld_q[slot_q];
    if (out_write) begin
      out_q <= acc;
    end
  end

  firc_ram #(
    .WIDTH (COEF_BITS),
    .DEPTH (TAPS)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (coef_we),
    .waddr_i (coef_waddr),
    .wdata_i (coeff_value_i),
    .raddr_i (k_q),
    .rdata_o (coef_rd)
  );

  firc_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (TAPS)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (is_filter),
    .waddr_i (wp_q),
    .wdata_i (smp_w),
    .raddr_i (slot_q),
    .rdata_o (hist_rd)
  );

  assign coef_op = coef_ok_q ? $signed(coef_rd) : '0;
  assign smp_op  = hist_ok_q ? hist_rd : '0;

  assign mac_ctrl.clear = is_filter;
  assign mac_ctrl.load  = (state_q == S_LOAD);
  assign mac_ctrl.step  = (state_q == S_MUL);
  assign mac_ctrl.last  = (state_q == S_MUL) && (dig_q == LAST_DIG);
  assign mac_ctrl.accum = (state_q == S_ACC);

  firc_dsmul #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dsmul (
    .clk_i    (clk_i),
    .ctrl_i   (mac_ctrl),
    .coef_i   (coef_op),
    .sample_i (smp_op),
    .acc_o    (acc)
  );

  assign out_valid_o      = out_valid_q;
  assign filtered_value_o = out_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> (cnt_q <= n_eff))
    else $error("tap count ran past the taps in use");

  a_dig_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL) |-> (dig_q <= LAST_DIG))
    else $error("digit counter ran past the last digit");

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(slot_q) < TAPS) && (32'(wp_q) < TAPS))
    else $error("ring pointer outside the history");

  a_filter_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_filter |=> (state_q == S_FETCH))
    else $error("filter transfer did not start a sweep");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result appeared without a finished sweep");
`endif

endmodule

// ===== tb/fir_filter_circular_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fir_filter_circular_test: self-checking bench for the circular-history FIR
// Drives filter, clear, load and spare items plus writes to the taps register.
// A behavioural filter predicts every sum. Each output transfer is checked
// against the oldest predicted sum, under several sender and receiver idle mixes.
// ----------------------------------------------------------------------------
module fir_filter_circular_test;
  import firc_pkg::*;

  localparam int NUM_TAPS       = 32;
  localparam int SETTLE_CYCLES  = NUM_TAPS * 4 + 8;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_REPORTS    = 20;
  localparam logic [1:0] ACT_SPARE = 2'd3;

  typedef struct {
    logic [1:0]         action;
    logic signed [15:0] sample;
    logic [4:0]         tap;
    logic signed [15:0] coeff;
  } fir_item_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         in_valid_i;
  logic                         in_stall_o;
  logic [1:0]                   action_i;
  logic signed [15:0]           sample_value_i;
  logic [4:0]                   tap_index_i;
  logic signed [15:0]           coeff_value_i;
  logic                         out_valid_o;
  logic                         out_stall_i;
  logic signed [OUT_BITS-1:0]   filtered_value_o;
  logic                         cfg_valid_i;
  logic                         cfg_ready_o;
  logic [CFG_BITS-1:0]          cfg_data_i;

  // behavioural copy of the filter state
  logic signed [15:0]           coeffs  [NUM_TAPS];
  logic signed [15:0]           history [NUM_TAPS];
  int unsigned                  wr_pos;
  logic [CFG_BITS-1:0]          taps_reg;
  logic signed [OUT_BITS-1:0]   pending_sums[$];

  int send_idle_pct;
  int stall_pct;
  int mismatches;
  int quiet_cycles;
  int n_items, n_filters, n_loads, n_clears, n_results, n_cfg;

  fir_filter_circular dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .action_i         (action_i),
    .sample_value_i   (sample_value_i),
    .tap_index_i      (tap_index_i),
    .coeff_value_i    (coeff_value_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .filtered_value_o (filtered_value_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_REPORTS) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    mismatches++;
  endtask

  // Sum of products for a new sample, advancing the ring.
  function automatic logic signed [OUT_BITS-1:0] filter_sample(input logic signed [15:0] x);
    int unsigned n;
    int unsigned slot;
    longint      acc;
    n = (taps_reg == 0) ? 1 : ((taps_reg > NUM_TAPS) ? NUM_TAPS : taps_reg);
    history[wr_pos] = x;
    acc = 0;
    for (int unsigned k = 0; k < n; k++) begin
      slot = (wr_pos + NUM_TAPS - k) % NUM_TAPS;
      acc += longint'(coeffs[k]) * longint'(history[slot]);
    end
    wr_pos = (wr_pos + 1) % NUM_TAPS;
    return acc[OUT_BITS-1:0];
  endfunction

  task automatic advance_filter(input fir_item_t it);
    n_items++;
    case (it.action)
      ACT_FILTER: begin
        pending_sums.push_back(filter_sample(it.sample));
        n_filters++;
      end
      ACT_CLEAR: begin
        foreach (history[i]) history[i] = '0;
        n_clears++;
      end
      ACT_LOAD: begin
        if (it.tap < NUM_TAPS) coeffs[it.tap] = it.coeff;
        n_loads++;
      end
      default: ;
    endcase
  endtask

  // Enter and leave at a falling edge; valid stays high after the transfer.
  task automatic send_item(input fir_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    action_i       <= it.action;
    sample_value_i <= it.sample;
    tap_index_i    <= it.tap;
    coeff_value_i  <= it.coeff;
    do @(posedge clk_i); while (in_stall_o);
    advance_filter(it);
    @(negedge clk_i);
  endtask

  // Hold off until every predicted sum has come and the block has gone quiet.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_taps(input logic [CFG_BITS-1:0] n);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= n;
    do @(posedge clk_i); while (!cfg_ready_o);
    taps_reg = n;
    n_cfg++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic signed [15:0] pick_value();
    case ($urandom_range(19))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return 16'sh0000;
      3:       return 16'shffff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic fir_item_t make_item(input logic [1:0] act,
                                          input logic signed [15:0] x,
                                          input logic [4:0] tap,
                                          input logic signed [15:0] c);
    fir_item_t it;
    it.action = act;
    it.sample = x;
    it.tap    = tap;
    it.coeff  = c;
    return it;
  endfunction

  // Unused fields carry random bits so that the block must ignore them.
  function automatic fir_item_t filter_item(input logic signed [15:0] x);
    return make_item(ACT_FILTER, x, 5'($urandom), 16'($urandom));
  endfunction

  function automatic fir_item_t load_item(input logic [4:0] tap, input logic signed [15:0] c);
    return make_item(ACT_LOAD, 16'($urandom), tap, c);
  endfunction

  function automatic fir_item_t random_item();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return filter_item(pick_value());
    if (r < 88) return load_item(5'($urandom), pick_value());
    if (r < 93) return make_item(ACT_CLEAR, 16'($urandom), 5'($urandom), 16'($urandom));
    return make_item(ACT_SPARE, 16'($urandom), 5'($urandom), 16'($urandom));
  endfunction

  function automatic logic [CFG_BITS-1:0] pick_taps();
    case ($urandom_range(9))
      0:       return 6'd0;
      1:       return 6'd1;
      2:       return 6'd32;
      3:       return 6'd33;
      4:       return 6'd63;
      5:       return 6'd31;
      default: return 6'($urandom);
    endcase
  endfunction

  // Zero coefficients after reset give zero; a spare action gives nothing.
  task automatic test_reset_state();
    send_item(make_item(ACT_SPARE, 16'sh7fff, 5'd31, 16'sh7fff));
    send_item(filter_item(16'sh7fff));
  endtask

  task automatic test_directed_extremes();
    write_taps(6'd32);
    send_item(load_item(5'd0, 16'sh7fff));
    send_item(load_item(5'd1, 16'sh8000));
    send_item(load_item(5'd31, 16'sh8000));
    send_item(load_item(5'd30, 16'sh0001));
    send_item(filter_item(16'sh7fff));
    send_item(filter_item(16'sh8000));
    send_item(filter_item(16'sh0000));
    send_item(filter_item(16'shffff));
    // history is zeroed, coefficients kept
    send_item(make_item(ACT_CLEAR, 16'sh7fff, 5'd31, 16'sh7fff));
    send_item(filter_item(16'sh0001));
    write_taps(6'd1);
    send_item(filter_item(16'sh8000));
    // zero taps act as one
    write_taps(6'd0);
    send_item(filter_item(16'sh7fff));
    // anything above the store depth is clamped
    write_taps(6'd63);
    send_item(filter_item(16'sh8000));
    write_taps(6'd33);
    send_item(filter_item(16'sh7fff));
  endtask

  // Drive the sum to its most positive and most negative values.
  task automatic test_full_scale();
    write_taps(6'd32);
    for (int i = 0; i < NUM_TAPS; i++) send_item(load_item(5'(i), 16'sh8000));
    repeat (NUM_TAPS + 1) send_item(filter_item(16'sh8000));
    for (int i = 0; i < NUM_TAPS; i++) send_item(load_item(5'(i), 16'sh7fff));
    repeat (NUM_TAPS + 1) send_item(filter_item(16'sh8000));
    repeat (8) send_item(filter_item(16'sh7fff));
  endtask

  task automatic test_random_traffic(input int idle_pct, input int hold_pct, input int n);
    send_idle_pct = idle_pct;
    stall_pct     = hold_pct;
    for (int chunk = 0; chunk < 3; chunk++) begin
      write_taps(pick_taps());
      repeat (n / 3) send_item(random_item());
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    action_i       = ACT_FILTER;
    sample_value_i = '0;
    tap_index_i    = '0;
    coeff_value_i  = '0;
    out_stall_i    = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_data_i     = '0;
    send_idle_pct  = 0;
    stall_pct      = 0;
    mismatches     = 0;
    n_items = 0; n_filters = 0; n_loads = 0; n_clears = 0; n_results = 0; n_cfg = 0;
    foreach (coeffs[i]) coeffs[i] = '0;
    foreach (history[i]) history[i] = '0;
    wr_pos   = 0;
    taps_reg = TAPS_RESET;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_state();
    test_directed_extremes();
    test_full_scale();
    test_random_traffic(0, 0, 310);
    test_random_traffic(86, 0, 310);
    test_random_traffic(0, 86, 310);
    test_random_traffic(16, 16, 310);

    settle();
    $display("Run covered %0d items: %0d filtered, %0d loads, %0d clears, %0d taps writes",
             n_items, n_filters, n_loads, n_clears, n_cfg);
    $display("%0d sums checked under four idle mixes, %0d mismatches", n_results, mismatches);
    if (mismatches == 0 && pending_sums.size() == 0) begin
      $display("** fir_filter_circular: PASSED **");
    end else begin
      $display("** fir_filter_circular: FAILED **");
    end
    $finish;
  end

  always @(negedge clk_i) begin
    if (rst_ni) out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    logic signed [OUT_BITS-1:0] want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_results++;
      if (pending_sums.size() == 0) begin
        report_mismatch($sformatf("sum %0d with no sample pending", filtered_value_o));
      end else begin
        want = pending_sums.pop_front();
        if (filtered_value_o !== want) begin
          report_mismatch($sformatf("filtered_value %0d, expected %0d", filtered_value_o, want));
        end
      end
    end
  end

  // Count cycles with no transfer on any channel.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", quiet_cycles);
      $display("** fir_filter_circular: FAILED **");
      $finish;
    end
  end

  initial quiet_cycles = 0;

endmodule

// ===== sim.f =====
hw/rtl/firc_pkg.sv
hw/rtl/firc_ram.sv
hw/rtl/firc_dsmul.sv
hw/rtl/fir_filter_circular.sv
tb/fir_filter_circular_test.sv
